// File: sv/assc_pkg.sv
package assc_pkg;

    // Field widths.
    localparam int STEP_W     = 32;
    localparam int FACT_W     = 16;
    localparam int FRAC_W     = 14;
    localparam int SQ_W       = 2 * FACT_W - FRAC_W;
    localparam int PROD_W     = STEP_W + SQ_W - FRAC_W;
    localparam int ITER_W     = 16;
    localparam int CODE_W     = 8;
    localparam int CMD_W      = 2;
    localparam int CLS_W      = 3;
    localparam int CNT_W      = 16;
    localparam int TOT_W      = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Parameter defaults.
    localparam int unsigned WINDOW_DEPTH_DEF = 16;
    localparam int unsigned GROW_STREAK_DEF  = 3;
    localparam int unsigned FAIL_LIMIT_DEF   = 5;

    // Commands.
    localparam logic [CMD_W-1:0] CMD_SUCCESS = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FAILURE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RESTART = 2'd2;

    // Outcome classes.
    localparam logic [CLS_W-1:0] CLS_EASY       = 3'd0;
    localparam logic [CLS_W-1:0] CLS_NORMAL     = 3'd1;
    localparam logic [CLS_W-1:0] CLS_HARD       = 3'd2;
    localparam logic [CLS_W-1:0] CLS_STIFFNESS  = 3'd3;
    localparam logic [CLS_W-1:0] CLS_STRUCTURAL = 3'd4;
    localparam logic [CLS_W-1:0] CLS_TERMINAL   = 3'd5;
    localparam logic [CLS_W-1:0] CLS_OTHER      = 3'd6;

    // Solver error codes with a meaning of their own.
    localparam logic [CODE_W-1:0] ERR_NONE     = 8'd0;
    localparam logic [CODE_W-1:0] ERR_STIFF_A  = 8'd4;
    localparam logic [CODE_W-1:0] ERR_STIFF_B  = 8'd8;
    localparam logic [CODE_W-1:0] ERR_TERMINAL = 8'd9;

    // One tenth in Q2.14, rounded to nearest.
    localparam logic [FACT_W-1:0] TENTH_Q14 = 16'd1638;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_STEP_INITIAL  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_MIN      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_MAX      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GROW_FACTOR   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SHRINK_FACTOR = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HARD_SHRINK   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_EASY_LIMIT    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_HARD_LIMIT    = 3'd7;

    // Configuration reset values.
    localparam logic [STEP_W-1:0] STEP_INITIAL_RST  = 32'd16777216;
    localparam logic [STEP_W-1:0] STEP_MIN_RST      = 32'd16777;
    localparam logic [STEP_W-1:0] STEP_MAX_RST      = 32'hFFFF_FFFF;
    localparam logic [FACT_W-1:0] GROW_FACTOR_RST   = 16'd24576;
    localparam logic [FACT_W-1:0] SHRINK_FACTOR_RST = 16'd8192;
    localparam logic [FACT_W-1:0] HARD_SHRINK_RST   = 16'd12288;
    localparam logic [ITER_W-1:0] EASY_LIMIT_RST    = 16'd100;
    localparam logic [ITER_W-1:0] HARD_LIMIT_RST    = 16'd500;

    // Microprogram.
    localparam int PC_W = 3;

    localparam logic [PC_W-1:0] PC_WAIT     = 3'd0;
    localparam logic [PC_W-1:0] PC_CLASSIFY = 3'd1;
    localparam logic [PC_W-1:0] PC_PUSH     = 3'd2;
    localparam logic [PC_W-1:0] PC_SCALE    = 3'd3;
    localparam logic [PC_W-1:0] PC_CLAMP    = 3'd4;
    localparam logic [PC_W-1:0] PC_DIV_INIT = 3'd5;
    localparam logic [PC_W-1:0] PC_DIV_STEP = 3'd6;
    localparam logic [PC_W-1:0] PC_OUT      = 3'd7;

    typedef enum logic [7:0] {
        OP_WAIT     = 8'b0000_0001,
        OP_CLASSIFY = 8'b0000_0010,
        OP_PUSH     = 8'b0000_0100,
        OP_SCALE    = 8'b0000_1000,
        OP_CLAMP    = 8'b0001_0000,
        OP_DIV_INIT = 8'b0010_0000,
        OP_DIV_STEP = 8'b0100_0000,
        OP_OUT      = 8'b1000_0000
    } uop_t;

    typedef enum logic [5:0] {
        JMP_NEVER       = 6'b00_0001,
        JMP_NO_ACCEPT   = 6'b00_0010,
        JMP_NOT_SUCCESS = 6'b00_0100,
        JMP_WIN_EMPTY   = 6'b00_1000,
        JMP_DIV_BUSY    = 6'b01_0000,
        JMP_OUT_BUSY    = 6'b10_0000
    } jcond_t;

    typedef struct packed {
        uop_t             op;
        jcond_t           cond;
        logic [PC_W-1:0]  target;
    } uword_t;

    typedef struct packed {
        logic no_accept;
        logic not_success;
        logic win_empty;
        logic div_busy;
        logic out_busy;
    } seq_flags_t;

    // Control store. A step whose jump is not taken falls through to the
    // next address; the last step wraps back to the wait step.
    function automatic uword_t ucode_rom(input logic [PC_W-1:0] pc);
        uword_t w;
        case (pc)
            PC_WAIT:     w = '{op: OP_WAIT,     cond: JMP_NO_ACCEPT,   target: PC_WAIT};
            PC_CLASSIFY: w = '{op: OP_CLASSIFY, cond: JMP_NOT_SUCCESS, target: PC_SCALE};
            PC_PUSH:     w = '{op: OP_PUSH,     cond: JMP_NEVER,       target: PC_WAIT};
            PC_SCALE:    w = '{op: OP_SCALE,    cond: JMP_NEVER,       target: PC_WAIT};
            PC_CLAMP:    w = '{op: OP_CLAMP,    cond: JMP_NEVER,       target: PC_WAIT};
            PC_DIV_INIT: w = '{op: OP_DIV_INIT, cond: JMP_WIN_EMPTY,   target: PC_OUT};
            PC_DIV_STEP: w = '{op: OP_DIV_STEP, cond: JMP_DIV_BUSY,    target: PC_DIV_STEP};
            PC_OUT:      w = '{op: OP_OUT,      cond: JMP_OUT_BUSY,    target: PC_OUT};
            default:     w = '{op: OP_WAIT,     cond: JMP_NO_ACCEPT,   target: PC_WAIT};
        endcase
        return w;
    endfunction

endpackage

// File: sv/assc_sequencer.sv
module assc_sequencer (
    input  logic                clk,
    input  logic                rst_n,
    input  assc_pkg::seq_flags_t flags,
    output assc_pkg::uword_t    ctrl
);
    import assc_pkg::*;

    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    uword_t          word;
    logic            take;

    always_comb
    begin
        word = ucode_rom(pc_reg);
        case (word.cond)
            JMP_NEVER:       take = 1'b0;
            JMP_NO_ACCEPT:   take = flags.no_accept;
            JMP_NOT_SUCCESS: take = flags.not_success;
            JMP_WIN_EMPTY:   take = flags.win_empty;
            JMP_DIV_BUSY:    take = flags.div_busy;
            JMP_OUT_BUSY:    take = flags.out_busy;
            default:         take = 1'b0;
        endcase
        // Falling through from the last address wraps to the wait step.
        pc_next = take ? word.target : pc_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= PC_WAIT;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

    assign ctrl = word;

endmodule

// File: sv/adaptive_step_size_controller.sv
// Flow: an accepted item is classified, pushed into the window (successes only), then scaled
// and clamped as its command asks; the window mean is formed by the bit-serial divider loop
// of the microprogram, which is skipped while the window is empty, and the result waits in
// the output step while the output stalls. A new item is taken only after the last one has
// reached the output register. Reset (asynchronous, active low) loads the register defaults
// and initial step and clears the counters, the window head, fill and sum, and out_valid.
module adaptive_step_size_controller #(
    parameter int unsigned WINDOW_DEPTH = assc_pkg::WINDOW_DEPTH_DEF,
    parameter int unsigned GROW_STREAK  = assc_pkg::GROW_STREAK_DEF,
    parameter int unsigned FAIL_LIMIT   = assc_pkg::FAIL_LIMIT_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [assc_pkg::CMD_W-1:0]        cmd,
    input  logic [assc_pkg::ITER_W-1:0]       iterations,
    input  logic [assc_pkg::CODE_W-1:0]       error_code,

    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [assc_pkg::STEP_W-1:0]       next_step,
    output logic [assc_pkg::CLS_W-1:0]        outcome_class,
    output logic [assc_pkg::CNT_W-1:0]        success_streak,
    output logic [assc_pkg::CNT_W-1:0]        failure_streak,
    output logic                              failure_limit_hit,
    output logic [assc_pkg::ITER_W-1:0]       mean_iterations,
    output logic [assc_pkg::TOT_W-1:0]        lifetime_successes,
    output logic [assc_pkg::TOT_W-1:0]        lifetime_failures,

    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [assc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [assc_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import assc_pkg::*;

    // The window sum never exceeds depth times the largest iteration count.
    localparam int SUM_W  = ITER_W + $clog2(WINDOW_DEPTH);
    localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
    localparam int HEAD_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int DCNT_W = $clog2(SUM_W + 1);
    localparam int MUL_W  = STEP_W + SQ_W;

    // ------------------------------------------------------------------
    // Sequencer: the control store walks one control word per cycle.
    // ------------------------------------------------------------------
    uword_t     ctrl;
    seq_flags_t flags;

    assc_sequencer u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .ctrl  (ctrl)
    );

    // ------------------------------------------------------------------
    // Configuration registers. The port is ready only in the wait step,
    // so a write never disturbs an item in flight.
    // ------------------------------------------------------------------
    logic [STEP_W-1:0] step_init_reg;
    logic [STEP_W-1:0] step_min_reg;
    logic [STEP_W-1:0] step_max_reg;
    logic [FACT_W-1:0] grow_reg;
    logic [FACT_W-1:0] shrink_reg;
    logic [FACT_W-1:0] hshrink_reg;
    logic [ITER_W-1:0] easy_reg;
    logic [ITER_W-1:0] hard_reg;

    assign cfg_ready = (ctrl.op == OP_WAIT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_init_reg <= STEP_INITIAL_RST;
            step_min_reg  <= STEP_MIN_RST;
            step_max_reg  <= STEP_MAX_RST;
            grow_reg      <= GROW_FACTOR_RST;
            shrink_reg    <= SHRINK_FACTOR_RST;
            hshrink_reg   <= HARD_SHRINK_RST;
            easy_reg      <= EASY_LIMIT_RST;
            hard_reg      <= HARD_LIMIT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_STEP_INITIAL:  step_init_reg <= cfg_data[STEP_W-1:0];
                REG_STEP_MIN:      step_min_reg  <= cfg_data[STEP_W-1:0];
                REG_STEP_MAX:      step_max_reg  <= cfg_data[STEP_W-1:0];
                REG_GROW_FACTOR:   grow_reg      <= cfg_data[FACT_W-1:0];
                REG_SHRINK_FACTOR: shrink_reg    <= cfg_data[FACT_W-1:0];
                REG_HARD_SHRINK:   hshrink_reg   <= cfg_data[FACT_W-1:0];
                REG_EASY_LIMIT:    easy_reg      <= cfg_data[ITER_W-1:0];
                REG_HARD_LIMIT:    hard_reg      <= cfg_data[ITER_W-1:0];
                default:           ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Datapath registers.
    // ------------------------------------------------------------------
    // Latched item.
    logic [CMD_W-1:0]  cmd_reg,   cmd_next;
    logic [ITER_W-1:0] iters_reg, iters_next;
    logic [CODE_W-1:0] code_reg,  code_next;

    // Controller state.
    logic [STEP_W-1:0] step_reg,       step_next;
    logic [CNT_W-1:0]  wins_reg,       wins_next;
    logic [CNT_W-1:0]  losses_reg,     losses_next;
    logic [TOT_W-1:0]  wins_tot_reg,   wins_tot_next;
    logic [TOT_W-1:0]  losses_tot_reg, losses_tot_next;
    logic [HEAD_W-1:0] head_reg,       head_next;
    logic [FILL_W-1:0] fill_reg,       fill_next;
    logic [SUM_W-1:0]  sum_reg,        sum_next;

    // Work registers of the microprogram.
    logic [CLS_W-1:0]  cls_reg,      cls_next;
    logic [SQ_W-1:0]   factor_reg,   factor_next;
    logic              do_scale_reg, do_scale_next;
    logic              clamp_en_reg, clamp_en_next;
    logic [PROD_W-1:0] acc_reg,      acc_next;
    logic [SUM_W-1:0]  div_q_reg,    div_q_next;
    logic [FILL_W-1:0] div_r_reg,    div_r_next;
    logic [DCNT_W-1:0] div_cnt_reg,  div_cnt_next;

    // Output register.
    logic              out_valid_reg,  out_valid_next;
    logic [STEP_W-1:0] out_step_reg,   out_step_next;
    logic [CLS_W-1:0]  out_cls_reg,    out_cls_next;
    logic [CNT_W-1:0]  out_wins_reg,   out_wins_next;
    logic [CNT_W-1:0]  out_losses_reg, out_losses_next;
    logic              out_limit_reg,  out_limit_next;
    logic [ITER_W-1:0] out_mean_reg,   out_mean_next;
    logic [TOT_W-1:0]  out_wtot_reg,   out_wtot_next;
    logic [TOT_W-1:0]  out_ltot_reg,   out_ltot_next;

    // Iteration window memory: one write and one registered read per cycle.
    logic [ITER_W-1:0] win_mem [WINDOW_DEPTH];
    logic [ITER_W-1:0] rd_reg;

    // ------------------------------------------------------------------
    // Arithmetic shared by the microprogram steps.
    // ------------------------------------------------------------------
    logic              in_accept;
    logic              out_busy;
    logic [CNT_W-1:0]  wins_inc;
    logic [CNT_W-1:0]  losses_inc;
    logic [TOT_W-1:0]  wins_tot_inc;
    logic [TOT_W-1:0]  losses_tot_inc;
    logic [2*FACT_W-1:0] sq_prod;
    logic [MUL_W-1:0]  scale_prod;
    logic [PROD_W-1:0] clamp_lo;
    logic [PROD_W-1:0] clamp_hi;
    logic [PROD_W-1:0] clamp_upper;
    logic [PROD_W-1:0] clamp_val;
    logic              win_full;
    logic [HEAD_W-1:0] head_wrap;
    logic [FILL_W:0]   div_trial;
    logic              div_fits;

    // The block takes an item only in the wait step of the microprogram.
    assign in_stall  = (ctrl.op != OP_WAIT);
    assign in_accept = in_valid && !in_stall;
    assign out_busy  = out_valid_reg && out_stall;

    // Counters saturate at their all-ones value.
    assign wins_inc       = (wins_reg == '1)       ? wins_reg       : wins_reg + 1'b1;
    assign losses_inc     = (losses_reg == '1)     ? losses_reg     : losses_reg + 1'b1;
    assign wins_tot_inc   = (wins_tot_reg == '1)   ? wins_tot_reg   : wins_tot_reg + 1'b1;
    assign losses_tot_inc = (losses_tot_reg == '1) ? losses_tot_reg : losses_tot_reg + 1'b1;

    // Squared shrink factor in Q4.28, taken as a Q4.14 factor.
    assign sq_prod = shrink_reg * shrink_reg;

    // Step times factor, truncated back to Q8.24 with headroom for the clamp.
    assign scale_prod = step_reg * factor_reg;

    // Clamp: the upper bound is applied first so that crossed bounds
    // resolve to the lower bound.
    assign clamp_lo    = PROD_W'(step_min_reg);
    assign clamp_hi    = PROD_W'(step_max_reg);
    assign clamp_upper = (acc_reg > clamp_hi) ? clamp_hi : acc_reg;
    assign clamp_val   = (clamp_upper < clamp_lo) ? clamp_lo : clamp_upper;

    assign win_full  = (fill_reg == FILL_W'(WINDOW_DEPTH));
    assign head_wrap = (head_reg == HEAD_W'(WINDOW_DEPTH - 1)) ? '0 : head_reg + 1'b1;

    // Restoring division, one quotient bit per step. The remainder stays
    // below the fill count, so one extra bit holds the shifted trial.
    assign div_trial = {div_r_reg, div_q_reg[SUM_W-1]};
    assign div_fits  = (div_trial >= {1'b0, fill_reg});

    // Jump conditions seen by the sequencer.
    always_comb
    begin
        flags.no_accept   = !in_accept;
        flags.not_success = (cmd_reg != CMD_SUCCESS);
        flags.win_empty   = (fill_reg == '0);
        flags.div_busy    = (div_cnt_reg != DCNT_W'(1));
        flags.out_busy    = out_busy;
    end

    // ------------------------------------------------------------------
    // Datapath: each control word selects what is loaded this cycle.
    // ------------------------------------------------------------------
    always_comb
    begin
        cmd_next        = cmd_reg;
        iters_next      = iters_reg;
        code_next       = code_reg;
        step_next       = step_reg;
        wins_next       = wins_reg;
        losses_next     = losses_reg;
        wins_tot_next   = wins_tot_reg;
        losses_tot_next = losses_tot_reg;
        head_next       = head_reg;
        fill_next       = fill_reg;
        sum_next        = sum_reg;
        cls_next        = cls_reg;
        factor_next     = factor_reg;
        do_scale_next   = do_scale_reg;
        clamp_en_next   = clamp_en_reg;
        acc_next        = acc_reg;
        div_q_next      = div_q_reg;
        div_r_next      = div_r_reg;
        div_cnt_next    = div_cnt_reg;
        out_step_next   = out_step_reg;
        out_cls_next    = out_cls_reg;
        out_wins_next   = out_wins_reg;
        out_losses_next = out_losses_reg;
        out_limit_next  = out_limit_reg;
        out_mean_next   = out_mean_reg;
        out_wtot_next   = out_wtot_reg;
        out_ltot_next   = out_ltot_reg;

        // A result taken this cycle frees the output register.
        out_valid_next = out_valid_reg && out_stall;

        case (ctrl.op)
            OP_WAIT:
            begin
                if (in_accept)
                begin
                    cmd_next   = cmd;
                    iters_next = iterations;
                    code_next  = error_code;
                end
            end

            OP_CLASSIFY:
            begin
                // Counters, class and the factor to apply. Unused commands
                // leave the state alone and report the catch-all class.
                cls_next      = CLS_OTHER;
                do_scale_next = 1'b0;
                clamp_en_next = 1'b0;
                factor_next   = SQ_W'(shrink_reg);
                case (cmd_reg)
                    CMD_SUCCESS:
                    begin
                        wins_tot_next = wins_tot_inc;
                        losses_next   = '0;
                        wins_next     = wins_inc;
                        clamp_en_next = 1'b1;
                        if (iters_reg < easy_reg)
                        begin
                            // Grow only once the streak has built up.
                            cls_next      = CLS_EASY;
                            do_scale_next = (wins_inc >= CNT_W'(GROW_STREAK));
                            factor_next   = SQ_W'(grow_reg);
                        end
                        else if (iters_reg < hard_reg)
                        begin
                            cls_next = CLS_NORMAL;
                        end
                        else
                        begin
                            // A hard success ends the streak after counting it.
                            cls_next      = CLS_HARD;
                            do_scale_next = 1'b1;
                            factor_next   = SQ_W'(hshrink_reg);
                            wins_next     = '0;
                        end
                    end

                    CMD_FAILURE:
                    begin
                        losses_tot_next = losses_tot_inc;
                        wins_next       = '0;
                        losses_next     = losses_inc;
                        clamp_en_next   = 1'b1;
                        do_scale_next   = 1'b1;
                        head_next       = '0;
                        fill_next       = '0;
                        sum_next        = '0;
                        if (code_reg == ERR_NONE)
                        begin
                            cls_next = CLS_OTHER;
                        end
                        else if (code_reg == ERR_TERMINAL)
                        begin
                            cls_next    = CLS_TERMINAL;
                            factor_next = SQ_W'(TENTH_Q14);
                        end
                        else if (code_reg == ERR_STIFF_A || code_reg == ERR_STIFF_B)
                        begin
                            cls_next = CLS_STIFFNESS;
                        end
                        else
                        begin
                            cls_next    = CLS_STRUCTURAL;
                            factor_next = sq_prod[2*FACT_W-1:FRAC_W];
                        end
                    end

                    CMD_RESTART:
                    begin
                        // The initial step is loaded as is, without the clamp.
                        step_next   = step_init_reg;
                        wins_next   = '0;
                        losses_next = '0;
                        head_next   = '0;
                        fill_next   = '0;
                        sum_next    = '0;
                    end

                    default:
                    begin
                    end
                endcase
            end

            OP_PUSH:
            begin
                // The memory read of the previous step returned the entry at
                // the head, which is the oldest one once the window is full.
                if (win_full)
                begin
                    sum_next = sum_reg - SUM_W'(rd_reg) + SUM_W'(iters_reg);
                end
                else
                begin
                    sum_next  = sum_reg + SUM_W'(iters_reg);
                    fill_next = fill_reg + 1'b1;
                end
                head_next = head_wrap;
            end

            OP_SCALE:
            begin
                acc_next = do_scale_reg ? scale_prod[MUL_W-1:FRAC_W] : PROD_W'(step_reg);
            end

            OP_CLAMP:
            begin
                if (clamp_en_reg)
                begin
                    step_next = clamp_val[STEP_W-1:0];
                end
            end

            OP_DIV_INIT:
            begin
                // With an empty window the sum is zero, so the quotient
                // register already holds the reported mean.
                div_q_next   = sum_reg;
                div_r_next   = '0;
                div_cnt_next = DCNT_W'(SUM_W);
            end

            OP_DIV_STEP:
            begin
                if (div_fits)
                begin
                    div_r_next = FILL_W'(div_trial - {1'b0, fill_reg});
                end
                else
                begin
                    div_r_next = div_trial[FILL_W-1:0];
                end
                div_q_next   = {div_q_reg[SUM_W-2:0], div_fits};
                div_cnt_next = div_cnt_reg - 1'b1;
            end

            OP_OUT:
            begin
                if (!out_busy)
                begin
                    out_valid_next  = 1'b1;
                    out_step_next   = step_reg;
                    out_cls_next    = cls_reg;
                    out_wins_next   = wins_reg;
                    out_losses_next = losses_reg;
                    out_limit_next  = (losses_reg >= CNT_W'(FAIL_LIMIT));
                    out_mean_next   = div_q_reg[ITER_W-1:0];
                    out_wtot_next   = wins_tot_reg;
                    out_ltot_next   = losses_tot_reg;
                end
            end

            default:
            begin
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg       <= STEP_INITIAL_RST;
            wins_reg       <= '0;
            losses_reg     <= '0;
            wins_tot_reg   <= '0;
            losses_tot_reg <= '0;
            head_reg       <= '0;
            fill_reg       <= '0;
            sum_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            step_reg       <= step_next;
            wins_reg       <= wins_next;
            losses_reg     <= losses_next;
            wins_tot_reg   <= wins_tot_next;
            losses_tot_reg <= losses_tot_next;
            head_reg       <= head_next;
            fill_reg       <= fill_next;
            sum_reg        <= sum_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload and work registers.
    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        iters_reg      <= iters_next;
        code_reg       <= code_next;
        cls_reg        <= cls_next;
        factor_reg     <= factor_next;
        do_scale_reg   <= do_scale_next;
        clamp_en_reg   <= clamp_en_next;
        acc_reg        <= acc_next;
        div_q_reg      <= div_q_next;
        div_r_reg      <= div_r_next;
        div_cnt_reg    <= div_cnt_next;
        out_step_reg   <= out_step_next;
        out_cls_reg    <= out_cls_next;
        out_wins_reg   <= out_wins_next;
        out_losses_reg <= out_losses_next;
        out_limit_reg  <= out_limit_next;
        out_mean_reg   <= out_mean_next;
        out_wtot_reg   <= out_wtot_next;
        out_ltot_reg   <= out_ltot_next;
    end

    // Window memory: read at the head while classifying, written at the
    // head in the push step that follows.
    always_ff @(posedge clk)
    begin
        if (ctrl.op == OP_CLASSIFY)
        begin
            rd_reg <= win_mem[head_reg];
        end
        if (ctrl.op == OP_PUSH)
        begin
            win_mem[head_reg] <= iters_reg;
        end
    end

    assign out_valid          = out_valid_reg;
    assign next_step          = out_step_reg;
    assign outcome_class      = out_cls_reg;
    assign success_streak     = out_wins_reg;
    assign failure_streak     = out_losses_reg;
    assign failure_limit_hit  = out_limit_reg;
    assign mean_iterations    = out_mean_reg;
    assign lifetime_successes = out_wtot_reg;
    assign lifetime_failures  = out_ltot_reg;

endmodule

// File: sv/assc_checker.sv
module assc_checker #(
    parameter int unsigned FAIL_LIMIT = assc_pkg::FAIL_LIMIT_DEF
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [assc_pkg::STEP_W-1:0]   next_step,
    input logic [assc_pkg::CLS_W-1:0]    outcome_class,
    input logic [assc_pkg::CNT_W-1:0]    success_streak,
    input logic [assc_pkg::CNT_W-1:0]    failure_streak,
    input logic                          failure_limit_hit
);
    import assc_pkg::*;

    // One item at a time: right after an item is taken the input stalls.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("second item accepted while one is in flight");

    // The limit flag follows the failure streak it reports.
    a_limit_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (failure_limit_hit == (failure_streak >= CNT_W'(FAIL_LIMIT))))
        else $error("failure limit flag disagrees with failure streak");

    // A success class always comes with a cleared failure streak.
    a_success_clears_fail: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (outcome_class == CLS_EASY || outcome_class == CLS_NORMAL ||
                       outcome_class == CLS_HARD)) |-> (failure_streak == '0))
        else $error("success reported with a nonzero failure streak");

    // A hard success and every classed failure end the success streak.
    a_streak_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (outcome_class == CLS_HARD || outcome_class == CLS_STIFFNESS ||
                       outcome_class == CLS_STRUCTURAL || outcome_class == CLS_TERMINAL))
        |-> (success_streak == '0))
        else $error("success streak kept after a hard success or a failure");

    // A held result stays put.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(next_step)))
        else $error("stalled result changed or vanished");

endmodule

bind adaptive_step_size_controller assc_checker #(
    .FAIL_LIMIT (FAIL_LIMIT)
) u_assc_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .next_step         (next_step),
    .outcome_class     (outcome_class),
    .success_streak    (success_streak),
    .failure_streak    (failure_streak),
    .failure_limit_hit (failure_limit_hit)
);
